// ===== rtl/shpc_pkg.sv =====
// ----------------------------------------------------------------------------
// shpc_pkg
// Shared types, constants and the half-step coil table for the stepper
// half-step position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package shpc_pkg;

    localparam int unsigned POS_BITS_DEF = 32;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned DUTY_W       = 10;
    localparam int unsigned COIL_W       = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned OUT_DATA_W   = 48;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(1000);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_NUDGE = 2'd2,
        ACT_HOME  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_STANDBY = 2'd0,
        CFG_DUTY_MOVING  = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic               at_target;
        logic [VALUE_W-1:0] position_now;
        logic [DUTY_W-1:0]  duty;
        logic [COIL_W-1:0]  coil_pattern;
    } t_result;

    typedef struct packed {
        logic [DUTY_W-1:0] standby;
        logic [DUTY_W-1:0] moving;
    } t_duty_cfg;

    // bit0 A-, bit1 A+, bit2 B-, bit3 B+
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [2:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'hA;
            3'd1:    pat = 4'h8;
            3'd2:    pat = 4'h9;
            3'd3:    pat = 4'h1;
            3'd4:    pat = 4'h5;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'h6;
            default: pat = 4'h2;
        endcase
        return pat;
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
        return (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// shpc_cfg_regs
// Duty configuration registers, saturated to the full-scale duty on read.
// ----------------------------------------------------------------------------
`default_nettype none

module shpc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [shpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [shpc_pkg::DUTY_W-1:0]     i_cfg_data,
    output shpc_pkg::t_duty_cfg                  o_duty
);

    logic [shpc_pkg::DUTY_W-1:0] r_standby;
    logic [shpc_pkg::DUTY_W-1:0] r_moving;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standby <= '0;
            r_moving  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                shpc_pkg::CFG_DUTY_STANDBY: r_standby <= i_cfg_data;
                shpc_pkg::CFG_DUTY_MOVING:  r_moving  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_duty.standby = shpc_pkg::clamp_duty(r_standby);
    assign o_duty.moving  = shpc_pkg::clamp_duty(r_moving);

endmodule

`default_nettype wire

// ===== rtl/shpc_core.sv =====
// ----------------------------------------------------------------------------
// shpc_core
// Position state and single-pass update for one command; the goal register
// holds base offset plus relative target, so a move needs one add and a nudge two.
// ----------------------------------------------------------------------------
`default_nettype none

module shpc_core #(
    parameter int unsigned POS_BITS = shpc_pkg::POS_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire shpc_pkg::t_action    i_action,
    input  wire logic [POS_BITS-1:0]  i_value,
    input  wire shpc_pkg::t_duty_cfg  i_duty,
    output shpc_pkg::t_result         o_result
);

    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] r_base;
    logic [POS_BITS-1:0] r_goal;
    logic                r_full;

    logic [POS_BITS-1:0] n_pos;
    logic [POS_BITS-1:0] n_base;
    logic [POS_BITS-1:0] n_goal;
    logic                n_full;
    logic                there;

    always_comb begin
        n_pos  = r_pos;
        n_base = r_base;
        n_goal = r_goal;
        n_full = r_full;
        case (i_action)
            shpc_pkg::ACT_MOVE: begin
                n_goal = r_base + i_value;
            end
            shpc_pkg::ACT_NUDGE: begin
                n_base = r_base + i_value;
                n_goal = r_goal + i_value;
            end
            shpc_pkg::ACT_HOME: begin
                n_full = 1'b1;
                n_pos  = '0;
                n_goal = r_base;
            end
            default: begin
                if ($signed(r_pos) < $signed(r_goal)) begin
                    n_pos = r_pos + POS_BITS'(1);
                end else if ($signed(r_goal) < $signed(r_pos)) begin
                    n_pos = r_pos - POS_BITS'(1);
                end
            end
        endcase
    end

    assign there = (n_pos == n_goal);

    always_comb begin
        o_result.coil_pattern = shpc_pkg::coil_lookup(n_pos[2:0]);
        o_result.duty         = (n_full && !there) ? i_duty.moving : i_duty.standby;
        o_result.position_now = shpc_pkg::VALUE_W'($signed(n_pos));
        o_result.at_target    = there;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_base <= '0;
            r_goal <= '0;
            r_full <= 1'b0;
        end else if (i_adv) begin
            r_pos  <= n_pos;
            r_base <= n_base;
            r_goal <= n_goal;
            r_full <= n_full;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stepper_half_step_position_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_position_controller
// Half-step position controller for a two-winding bipolar stepper: input
// register, single-pass state update, result register.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s        | in        | tuser: action; tdata: value
//  m        | out       | tdata: coil_pattern, duty, position_now, at_target
//  cfg      | in        | index 0 duty_standby, 1 duty_moving; data: duty
//
//  one transfer in, one result out per cycle unless the output stalls
//  each command passes the input register, then the result register
//  the input stage refills in the same cycle a result is taken
//  reset clears position, offset, target, full power and both duties
//  a stalled output holds its result and backs up into the input stage
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_half_step_position_controller #(
    parameter int unsigned POS_BITS = shpc_pkg::POS_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // slave side
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [1:0]                        i_s_tuser,  // [1:0] action
    input  wire logic [shpc_pkg::VALUE_W-1:0]      i_s_tdata,  // [31:0] value
    // master side
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [3:0] coil_pattern, [13:4] duty, [45:14] position_now, [46] at_target
    output logic [shpc_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    // configuration
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [shpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [shpc_pkg::DUTY_W-1:0]       i_cfg_data
);

    logic                  r_in_valid;
    shpc_pkg::t_action     r_action;
    logic [POS_BITS-1:0]   r_value;
    logic                  r_out_valid;
    shpc_pkg::t_result     r_result;

    logic                  adv;
    shpc_pkg::t_result     core_result;
    shpc_pkg::t_duty_cfg   duty_cfg;

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    shpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_duty      (duty_cfg)
    );

    shpc_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_action (r_action),
        .i_value  (r_value),
        .i_duty   (duty_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_action <= shpc_pkg::t_action'(i_s_tuser);
            r_value  <= i_s_tdata[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= core_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_result};

endmodule

`default_nettype wire

// ===== tb/sv/stepper_half_step_position_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_half_step_position_controller_tb
// Drives tick, move, nudge and home commands into the half-step position
// controller and checks every result against a literal expected value or a
// cycle-free model of the step, offset, target and duty state. A short
// directed table comes first, then random command runs under several duty
// settings, with random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module stepper_half_step_position_controller_tb;
    import shpc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [COIL_W-1:0] HALF_STEP [8] = '{
        4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2
    };

    typedef struct {
        t_action      act;
        logic [31:0]  value;
        bit           literal;
        t_result      result;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [1:0]            i_s_tuser   = '0;  // [1:0] action
    logic [VALUE_W-1:0]    i_s_tdata   = '0;  // [31:0] value
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // [3:0] coil_pattern, [13:4] duty, [45:14] position_now, [46] at_target
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DUTY_W-1:0]     i_cfg_data  = '0;

    // model state
    logic [31:0]       cur_step;
    logic [31:0]       base_step;
    logic [31:0]       rel_target;
    bit                full_power_on;
    logic [DUTY_W-1:0] duty_hold;
    logic [DUTY_W-1:0] duty_run;

    t_result     pending_results [$];
    t_result     got, want;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_kick    = 1'b0;
    bit          hold_seen    = 1'b0;
    int unsigned hold_left    = 0;

    t_row script [0:25] = '{
        '{ACT_TICK,  32'h0000_0000, 1'b1, {1'b1, 32'd0, 10'd0, 4'hA}},
        '{ACT_MOVE,  32'h7FFF_FFFF, 1'b1, {1'b0, 32'd0, 10'd0, 4'hA}},
        // standby above range from here on
        '{ACT_TICK,  32'hFFFF_FFFF, 1'b1, {1'b0, 32'd1, 10'd1000, 4'h8}},
        '{ACT_HOME,  32'h8000_0000, 1'b1, {1'b1, 32'd0, 10'd1000, 4'hA}},
        '{ACT_MOVE,  32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_MOVE,  32'h8000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h5555_5555, 1'b0, '0},
        '{ACT_TICK,  32'hAAAA_AAAA, 1'b0, '0},
        '{ACT_NUDGE, 32'h7FFF_FFFF, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_NUDGE, 32'h0000_0001, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_MOVE,  32'h0000_0004, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        // home keeps the base offset, ticks then walk toward it
        '{ACT_HOME,  32'h0000_0000, 1'b0, '0},
        '{ACT_NUDGE, 32'hFFFF_FFFC, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
        '{ACT_NUDGE, 32'h8000_0000, 1'b0, '0}
    };

    stepper_half_step_position_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_result advance_position(input t_action act, input logic [31:0] val);
        logic [31:0]       goal;
        logic [DUTY_W-1:0] sel;
        t_result           r;
        case (act)
            ACT_MOVE: rel_target = val;
            ACT_NUDGE: base_step = base_step + val;
            ACT_HOME: begin
                full_power_on = 1'b1;
                rel_target    = '0;
                cur_step      = '0;
            end
            default: begin
                goal = base_step + rel_target;
                if ($signed(cur_step) < $signed(goal))
                    cur_step = cur_step + 32'd1;
                else if ($signed(goal) < $signed(cur_step))
                    cur_step = cur_step - 32'd1;
            end
        endcase
        goal           = base_step + rel_target;
        r.at_target    = (cur_step == goal);
        r.position_now = cur_step;
        r.coil_pattern = HALF_STEP[cur_step[2:0]];
        sel            = (full_power_on && !r.at_target) ? duty_run : duty_hold;
        r.duty         = (sel > DUTY_MAX) ? DUTY_MAX : sel;
        return r;
    endfunction

    task automatic send_command(input t_action act, input logic [31:0] val,
                                input bit literal, input t_result literal_res);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= val;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = advance_position(act, val);
        pending_results.push_back(literal ? literal_res : predicted);
    endtask

    task automatic write_duty(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DUTY_STANDBY: duty_hold = data;
            CFG_DUTY_MOVING:  duty_run  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic play_script(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_command(script[i].act, script[i].value, script[i].literal, script[i].result);
    endtask

    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return $urandom_range(24) - 12;
        if (roll < 85)
            return 32'h7FFF_FFFF;
        if (roll < 90)
            return 32'h8000_0000;
        return $urandom();
    endfunction

    // a command followed by a run of ticks, so nearby targets can be reached
    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        t_action     act;
        logic [31:0] val;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 40)
                act = ACT_MOVE;
            else if (pick < 70)
                act = ACT_NUDGE;
            else if (pick < 82)
                act = ACT_HOME;
            else
                act = ACT_TICK;
            val = pick_value();
            if (act == ACT_NUDGE && $urandom_range(4) == 0)
                val = -base_step;
            send_command(act, val, 1'b0, '0);
            sent++;
            repeat ($urandom_range(16, 1)) begin
                send_command(ACT_TICK, $urandom(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // output side ready, with a long hold-off each time hold_kick toggles
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen  <= hold_kick;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[46:0]);
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", o_m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern expected %h got %h", want.coil_pattern,
                           got.coil_pattern);
                    mismatches++;
                end
                if (got.duty !== want.duty) begin
                    $error("duty expected %0d got %0d", want.duty, got.duty);
                    mismatches++;
                end
                if (got.position_now !== want.position_now) begin
                    $error("position_now expected %0d got %0d", $signed(want.position_now),
                           $signed(got.position_now));
                    mismatches++;
                end
                if (got.at_target !== want.at_target) begin
                    $error("at_target expected %0b got %0b", want.at_target, got.at_target);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stepper_half_step_position_controller_tb failed");
            $finish;
        end
    end

    initial begin
        cur_step      = '0;
        base_step     = '0;
        rel_target    = '0;
        full_power_on = 1'b0;
        duty_hold     = '0;
        duty_run      = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly active, receiver mostly stalled
        send_idle_pct = 16;
        recv_idle_pct = 75;
        play_script(0, 1);
        wait_results_done();
        write_duty(CFG_DUTY_STANDBY, 10'd1023);
        write_duty(CFG_DUTY_MOVING, 10'd5);
        write_duty(CFG_SPARE_2, 10'h155);
        write_duty(CFG_SPARE_3, 10'h2AA);
        play_script(2, 25);
        wait_results_done();
        write_duty(CFG_DUTY_STANDBY, 10'd0);
        write_duty(CFG_DUTY_MOVING, 10'd1000);
        run_random(140);
        wait_results_done();

        // the other way round
        send_idle_pct = 75;
        recv_idle_pct = 16;
        write_duty(CFG_DUTY_STANDBY, 10'd1000);
        write_duty(CFG_DUTY_MOVING, 10'd1023);
        run_random(140);
        wait_results_done();

        // full rate, starting under a long output hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_duty(CFG_DUTY_STANDBY, 10'd512);
        write_duty(CFG_DUTY_MOVING, 10'd0);
        hold_kick <= ~hold_kick;
        run_random(130);
        wait_results_done();

        write_duty(CFG_DUTY_STANDBY, 10'($urandom_range(1023)));
        write_duty(CFG_DUTY_MOVING, 10'($urandom_range(1023)));
        write_duty(CFG_SPARE_3, 10'd0);
        run_random(120);
        wait_results_done();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("stepper_half_step_position_controller_tb passed");
        else
            $display("stepper_half_step_position_controller_tb failed");
        $finish;
    end

endmodule
